[rtl/core/nphtag_pkg.sv]
// Package with shared types, constants and the tag fold function for the name hash tag block.
package nphtag_pkg;

  localparam logic [31:0] FNV_OFFSET_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME        = 32'd16777619;
  localparam logic [11:0] TAG_MODULUS      = 12'd4095;
  localparam logic [7:0]  SEPARATOR_RESET  = 8'd35;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified transaction as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       chr_valid;
    logic       is_sep;
    logic       last;
  } nphtag_item_t;

  // Tag = 1 + (value mod 4095). Since 4096 is 1 mod 4095, the 12-bit digits are summed
  // and folded once more, then one conditional subtract finishes the remainder.
  function automatic logic [11:0] nphtag_fold(input logic [31:0] value);
    logic [13:0] s1;
    logic [12:0] s2;
    logic [12:0] rem;
    s1  = {2'b00, value[11:0]} + {2'b00, value[23:12]} + {6'b000000, value[31:24]};
    s2  = {1'b0, s1[11:0]} + {11'b0, s1[13:12]};
    rem = (s2 >= {1'b0, TAG_MODULUS}) ? (s2 - {1'b0, TAG_MODULUS}) : s2;
    return rem[11:0] + 12'd1;
  endfunction

endpackage

[rtl/core/nphtag_front.sv]
// Front end: separator register, input acceptance and classification of each character.
module nphtag_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_separator_byte,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_name_byte,
  input  logic                       in_byte_valid,
  input  logic                       in_last_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output nphtag_pkg::nphtag_item_t   q_item
);
  import nphtag_pkg::*;

  logic [7:0] sep_r;
  logic [7:0] sep_nxt;

  assign cfg_ready = 1'b1;
  assign sep_nxt   = (cfg_valid && cfg_ready) ? cfg_separator_byte : sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEPARATOR_RESET;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  assign in_ready = !q_full;

  // An invalid item that does not end the name changes nothing, so it is dropped here.
  assign q_push = in_valid && in_ready && (in_byte_valid || in_last_byte);

  always_comb begin
    q_item.ch        = in_name_byte;
    q_item.chr_valid = in_byte_valid;
    q_item.is_sep    = in_byte_valid && (in_name_byte == sep_r);
    q_item.last      = in_last_byte;
  end

endmodule

[rtl/core/nphtag_queue.sv]
// Short queue of classified items between the front end and the hash back end.
module nphtag_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  nphtag_pkg::nphtag_item_t   push_item,
  output logic                       full,
  input  logic                       pop,
  output logic                       head_valid,
  output nphtag_pkg::nphtag_item_t   head_item
);
  import nphtag_pkg::*;

  nphtag_item_t   mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (QAW+1)'(1);
      2'b01:   count_nxt = count_r - (QAW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/nphtag_back.sv]
// Back end: running hash update, prefix capture, tag fold stage and output register.
module nphtag_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  nphtag_pkg::nphtag_item_t   head_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [11:0]                out_tag
);
  import nphtag_pkg::*;

  logic [31:0] running_r;
  logic [31:0] running_nxt;
  logic [31:0] prefix_r;
  logic [31:0] prefix_nxt;
  logic        seen_r;
  logic        seen_nxt;
  logic        fold_valid_r;
  logic        fold_valid_nxt;
  logic [31:0] fold_val_r;
  logic [31:0] fold_val_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [11:0] out_tag_r;
  logic [11:0] out_tag_nxt;
  logic        fold_adv;
  logic        fold_free;
  logic [31:0] hash_upd;
  logic [31:0] prefix_upd;
  logic        seen_upd;

  assign fold_adv  = fold_valid_r && (!out_valid_r || out_ready);
  assign fold_free = !fold_valid_r || fold_adv;
  assign pop       = head_valid && (!head_item.last || fold_free);

  assign hash_upd   = head_item.chr_valid
                    ? (running_r ^ {24'd0, head_item.ch}) * FNV_PRIME
                    : running_r;
  assign prefix_upd = head_item.is_sep ? running_r : prefix_r;
  assign seen_upd   = seen_r || head_item.is_sep;

  always_comb begin
    running_nxt    = running_r;
    prefix_nxt     = prefix_r;
    seen_nxt       = seen_r;
    fold_valid_nxt = fold_valid_r && !fold_adv;
    fold_val_nxt   = fold_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_tag_nxt    = out_tag_r;
    if (fold_adv) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = nphtag_fold(fold_val_r);
    end
    if (pop) begin
      if (head_item.last) begin
        fold_valid_nxt = 1'b1;
        fold_val_nxt   = seen_upd ? prefix_upd : hash_upd;
        running_nxt    = FNV_OFFSET_BASIS;
        prefix_nxt     = '0;
        seen_nxt       = 1'b0;
      end else begin
        running_nxt = hash_upd;
        prefix_nxt  = prefix_upd;
        seen_nxt    = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= FNV_OFFSET_BASIS;
      prefix_r     <= '0;
      seen_r       <= 1'b0;
      fold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      running_r    <= running_nxt;
      prefix_r     <= prefix_nxt;
      seen_r       <= seen_nxt;
      fold_valid_r <= fold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fold_val_r <= fold_val_nxt;
    out_tag_r  <= out_tag_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;

endmodule

[rtl/core/name_prefix_hash_tag_core.sv]
// A last transaction's tag reaches out_tag through the queue, fold and output registers.
// Throughput: one input transaction per cycle while the queue is not full, set by the
// combinational xor and prime multiply that closes the running-hash loop in the back end.
// Reset: synchronous active-low rst_n restores the offset basis, clears the prefix copy and
// the separator flag, empties the queue and pipeline, and loads separator 35 ('#').
module name_prefix_hash_tag_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_separator_byte,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_tag
);
  import nphtag_pkg::*;

  // Handoff between the front end and the queue, and between the queue and the back end.
  logic         q_full;
  logic         q_push;
  nphtag_item_t q_item;
  logic         q_pop;
  logic         q_head_valid;
  nphtag_item_t q_head_item;

  // The front end holds the separator register and compares each incoming character against
  // it, so the back end only sees a ready-made separator flag. Transactions that are neither
  // a character nor an end-of-name marker are accepted and discarded right here.
  nphtag_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_separator_byte (cfg_separator_byte),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_byte       (in_name_byte),
    .in_byte_valid      (in_byte_valid),
    .in_last_byte       (in_last_byte),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_item)
  );

  // The two-entry queue decouples input acceptance from the back end. Because in_ready only
  // depends on the registered fill level, no combinational path runs from out_ready to
  // in_ready, and a free entry keeps the input moving while a tag waits at the output.
  nphtag_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // The back end folds one character per cycle into the running hash, bar stalls at a name end.
  // On the end of a name it registers the chosen hash (the prefix copy if a separator was seen),
  // resets its name state, and the next stage reduces that value to the 12-bit tag in the output
  // register. A new name can start in the next cycle while the previous tag is being delivered.
  nphtag_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_tag    (out_tag)
  );

endmodule

[bench/tb.sv]
// Self-checking testbench for the name prefix hash tag core, with a scoreboard that predicts each tag.
module tb;
  import nphtag_pkg::*;

  // SETTLE_CYCLES exceeds the path through the queue, fold and output registers, so it covers any
  // transaction still in flight once the last expected tag has been seen.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 320;

  // Scoreboard: it keeps its own copy of the hash state and the separator register. Every
  // accepted input transaction advances that state, and each last transaction queues the tag
  // that the core must produce. Tags leave the core in order, so a plain FIFO is enough.
  class tag_scoreboard;
    logic [31:0] running_hash;
    logic [31:0] prefix_hash;
    bit          sep_seen;
    logic [7:0]  separator;
    logic [11:0] expected_tags[$];
    int          mismatch_count;

    function new();
      separator      = SEPARATOR_RESET;
      mismatch_count = 0;
      clear_name();
    endfunction

    function void clear_name();
      running_hash = FNV_OFFSET_BASIS;
      prefix_hash  = 32'd0;
      sep_seen     = 1'b0;
    endfunction

    function void set_separator(logic [7:0] value);
      separator = value;
    endfunction

    function void note_byte(logic [7:0] ch, logic chr_valid, logic last);
      logic [31:0] chosen;
      logic [31:0] rem;
      if (chr_valid) begin
        // The copy is taken before the separator itself goes into the hash.
        if (ch == separator) begin
          prefix_hash = running_hash;
          sep_seen    = 1'b1;
        end
        running_hash = (running_hash ^ {24'd0, ch}) * FNV_PRIME;
      end
      if (last) begin
        chosen = sep_seen ? prefix_hash : running_hash;
        rem    = chosen % {20'd0, TAG_MODULUS};
        expected_tags.insert(expected_tags.size(), rem[11:0] + 12'd1);
        clear_name();
      end
    endfunction

    function void check_tag(logic [11:0] actual);
      logic [11:0] wanted;
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected tag, expected none, actual %0d", $time, actual);
        mismatch_count++;
      end else begin
        wanted = expected_tags.pop_front();
        if (actual !== wanted) begin
          $display("%0t: tag mismatch, expected %0d, actual %0d", $time, wanted, actual);
          mismatch_count++;
        end
      end
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction
  endclass

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_separator_byte = 8'd0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [7:0]  in_name_byte       = 8'd0;
  logic        in_byte_valid      = 1'b0;
  logic        in_last_byte       = 1'b0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [11:0] out_tag;

  tag_scoreboard sb = new();

  // While calm is set neither side idles, which gives long stretches at full rate.
  bit calm = 1'b0;
  int cycles = 0;

  name_prefix_hash_tag_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_separator_byte (cfg_separator_byte),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_byte       (in_name_byte),
    .in_byte_valid      (in_byte_valid),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tag            (out_tag)
  );

  always #6 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Idle length for either side: usually none, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // All inputs change only at rising edges, so by the falling edge the ready signals hold the
  // value that the next rising edge will see. Handshakes are therefore judged at the falling
  // edge, which keeps the checks free of races against the core's own updates.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tag(out_tag);
  end

  // Result side back-pressure.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Drives one input transaction, starting and ending at a rising edge. Valid stays high when
  // the next transaction follows with no gap, so it is never dropped and raised in one step.
  task automatic send_item(input logic [7:0] ch, input logic chr_valid, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_name_byte  <= ch;
    in_byte_valid <= chr_valid;
    in_last_byte  <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_byte(ch, chr_valid, last);
  endtask

  // Stops the sender and waits until every queued tag has come back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    cfg_valid          <= 1'b1;
    cfg_separator_byte <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_separator(value);
  endtask

  // Character mix: the separator often, printable text mostly, and the full byte range too.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return sb.separator;
    if (roll < 60) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // Random names. Most are well formed with random content; some are empty, some end on a
  // terminator without a character, and some carry ignored transactions in the middle. Once
  // half the phase is out, the sender pauses until all tags have returned.
  task automatic send_random_names(input int target);
    int  sent;
    int  len;
    bit  paused;
    bit  end_on_terminator;
    sent   = 0;
    paused = 1'b0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 5) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        end_on_terminator = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          send_item(pick_char(), 1'b1, (i == len - 1) && !end_on_terminator);
          sent++;
        end
        if (end_on_terminator) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          sent++;
        end
      end
      if (!paused && sent >= target / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [7:0] phase_sep[5];
    phase_sep[0] = 8'h00;
    phase_sep[1] = 8'hFF;
    phase_sep[2] = SEPARATOR_RESET;
    phase_sep[3] = 8'($urandom_range(1, 254));
    phase_sep[4] = 8'($urandom_range(0, 255));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names under the reset separator '#'.
    // An empty name: a terminator with no characters gives the tag of the offset basis.
    send_item(8'h00, 1'b0, 1'b1);
    // Single characters at both ends of the byte range, each carrying last.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // A suffix after the separator is stripped.
    send_item("a", 1'b1, 1'b0);
    send_item("#", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);
    // The separator as the final character.
    send_item("x", 1'b1, 1'b0);
    send_item("#", 1'b1, 1'b1);
    // Two separators: the copy belongs to the second one.
    send_item("#", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("#", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    // An ignored transaction in the middle of a name must not disturb the hash.
    send_item("q", 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item("r", 1'b1, 1'b1);
    // A terminator without a character ends a non-empty name.
    send_item("z", 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    // A lone separator leaves the offset basis as the prefix.
    send_item("#", 1'b1, 1'b1);
    drain();

    // Random phases, each under its own separator setting; the third runs without idling.
    for (int p = 0; p < 5; p++) begin
      write_separator(phase_sep[p]);
      calm = (p == 2);
      send_random_names(PHASE_ITEMS);
      drain();
    end

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
